>>> rtl/core/rarst_pkg.sv
package rarst_pkg;

  localparam int unsigned POSITIONS_DEF = 1024;

  localparam int CMD_W     = 2;
  localparam int LO_W      = 10;
  localparam int HI_W      = 11;
  localparam int DELTA_W   = 32;
  localparam int SUM_W     = 64;
  localparam int IN_DATA_W = 56;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_SUM   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_MUL2,
    ST_WB,
    ST_EMIT
  } state_t;

endpackage

>>> rtl/core/range_add_range_sum_tree.sv
// Channel  Dir  Ports                          Beat contents
// in       in   in_tvalid/in_tready/in_tdata   cmd, lo, hi, delta
// out      out  out_tvalid/out_tready/out_tdata range_sum
//
// Each add or sum with a nonempty range walks the tree from the root, one node at a
// time. The accept cycle issues the root read; then each node passes through a
// multiply state and a write-back state that also issues the next node's read, with a
// second multiply state for a partly covered node of a sum, whose 64-bit tag is
// multiplied in two 32-bit halves on the one multiplier. A sum ends in an output
// state; an empty add goes straight back to idle and an empty sum straight to output.
// After reset and after a clear command the node memory is zeroed in a sweep over
// all 2*POSITIONS-1 nodes during which no beat is accepted.
// A finished sum waits in the output register; the next beat is taken meanwhile,
// and a later sum stalls in its output state until that register is free.
module range_add_range_sum_tree #(
  parameter int POSITIONS = rarst_pkg::POSITIONS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [1:0] cmd, [11:2] lo, [22:12] hi, [54:23] delta, [55] zero
  input  logic [rarst_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [63:0] range_sum
  output logic [rarst_pkg::SUM_W-1:0]     out_tdata
);

  localparam int NODES  = 2 * POSITIONS - 1;
  localparam int IDW    = $clog2(NODES);
  localparam int PW     = $clog2(POSITIONS + 1);
  localparam int XW     = (PW > rarst_pkg::HI_W) ? PW : rarst_pkg::HI_W;
  localparam int LEVELS = $clog2(POSITIONS);
  localparam int STK_D  = LEVELS + 1;
  localparam int NW     = IDW + 2 * XW;
  localparam int MW     = 33 + XW + 1;
  localparam int SW     = rarst_pkg::SUM_W;

  rarst_pkg::state_t state_r, state_nxt;

  logic [IDW-1:0]                  id_r, id_nxt;
  logic [XW-1:0]                   l_r, l_nxt, r_r, r_nxt;
  logic [XW-1:0]                   a_r, a_nxt, b_r, b_nxt;
  logic [rarst_pkg::DELTA_W-1:0]   d_r, d_nxt;
  logic                            is_sum_r, is_sum_nxt;
  logic [SW-1:0]                   acc_r, acc_nxt, prod_r, prod_nxt;
  logic [IDW-1:0]                  clr_r, clr_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [SW-1:0]                   out_data_r, out_data_nxt;

  // Input beat fields.
  logic [rarst_pkg::CMD_W-1:0]   in_cmd;
  logic [rarst_pkg::LO_W-1:0]    in_lo;
  logic [rarst_pkg::HI_W-1:0]    in_hi;
  logic [rarst_pkg::DELTA_W-1:0] in_delta;
  logic [XW-1:0]                 lo_x, hi_x, hi_c, pos_x;
  logic                          nonempty, in_fire;

  assign in_cmd   = in_tdata[1:0];
  assign in_lo    = in_tdata[11:2];
  assign in_hi    = in_tdata[22:12];
  assign in_delta = in_tdata[54:23];
  assign lo_x     = XW'(in_lo);
  assign hi_x     = XW'(in_hi);
  assign pos_x    = XW'(POSITIONS);
  assign hi_c     = (hi_x > pos_x) ? pos_x : hi_x;
  assign nonempty = (lo_x < hi_c);
  assign in_tready = (state_r == rarst_pkg::ST_IDLE);
  assign in_fire  = in_tvalid && in_tready;

  // Node geometry of the current node.
  logic [XW-1:0]  mid, lo_e, hi_e, ov, half;
  logic [XW:0]    half2;
  logic [IDW-1:0] lid, rid;
  logic           full, lint, rint;

  assign mid   = l_r + ((r_r - l_r) >> 1);
  assign lo_e  = (a_r > l_r) ? a_r : l_r;
  assign hi_e  = (b_r < r_r) ? b_r : r_r;
  assign ov    = hi_e - lo_e;
  assign full  = (a_r <= l_r) && (b_r >= r_r);
  assign half  = mid - l_r;
  assign half2 = {half, 1'b0};
  assign lid   = id_r + IDW'(1);
  assign rid   = id_r + IDW'(half2);
  assign lint  = (a_r < mid) && (b_r > l_r);
  assign rint  = (a_r < r_r) && (b_r > mid);

  // Node memory and pending-node stack.
  logic          mem_we, mem_re;
  logic [IDW-1:0] mem_waddr, mem_raddr;
  logic [SW-1:0] mem_wtag, mem_wtotal, rd_tag, rd_total;
  logic          push, pop, stk_empty;
  logic [NW-1:0] push_data, stk_top;

  rarst_node_mem #(
    .DEPTH (NODES),
    .AW    (IDW)
  ) u_mem (
    .clk        (clk),
    .wr_en      (mem_we),
    .wr_addr    (mem_waddr),
    .wr_tag     (mem_wtag),
    .wr_total   (mem_wtotal),
    .rd_en      (mem_re),
    .rd_addr    (mem_raddr),
    .rd_tag_r   (rd_tag),
    .rd_total_r (rd_total)
  );

  rarst_node_stack #(
    .W     (NW),
    .DEPTH (STK_D)
  ) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .top       (stk_top),
    .empty     (stk_empty)
  );

  // Shared multiplier: delta or one tag half times the overlap length.
  logic signed [32:0]   mul_a;
  logic signed [XW:0]   mul_b;
  logic signed [MW-1:0] mul_p;
  logic [SW-1:0]        mul_ext;

  always_comb begin
    if (state_r == rarst_pkg::ST_MUL2) begin
      mul_a = $signed({1'b0, rd_tag[63:32]});
    end else if (is_sum_r) begin
      mul_a = $signed({1'b0, rd_tag[31:0]});
    end else begin
      mul_a = $signed({d_r[31], d_r});
    end
  end

  assign mul_b   = $signed({1'b0, ov});
  assign mul_p   = mul_a * mul_b;
  assign mul_ext = {{(SW - MW){mul_p[MW-1]}}, mul_p};

  logic have_next;
  assign have_next = (!full && (lint || rint)) || !stk_empty;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rarst_pkg::ST_CLEAR: begin
        if (clr_r == IDW'(NODES - 1)) state_nxt = rarst_pkg::ST_IDLE;
      end
      rarst_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_cmd)
            rarst_pkg::CMD_ADD: state_nxt = nonempty ? rarst_pkg::ST_MUL : rarst_pkg::ST_IDLE;
            rarst_pkg::CMD_SUM: state_nxt = nonempty ? rarst_pkg::ST_MUL : rarst_pkg::ST_EMIT;
            rarst_pkg::CMD_CLEAR: state_nxt = rarst_pkg::ST_CLEAR;
            default: state_nxt = rarst_pkg::ST_IDLE;
          endcase
        end
      end
      rarst_pkg::ST_MUL: begin
        state_nxt = (is_sum_r && !full) ? rarst_pkg::ST_MUL2 : rarst_pkg::ST_WB;
      end
      rarst_pkg::ST_MUL2: state_nxt = rarst_pkg::ST_WB;
      rarst_pkg::ST_WB: begin
        if (have_next) begin
          state_nxt = rarst_pkg::ST_MUL;
        end else begin
          state_nxt = is_sum_r ? rarst_pkg::ST_EMIT : rarst_pkg::ST_IDLE;
        end
      end
      rarst_pkg::ST_EMIT: begin
        if (!out_valid_r || out_tready) state_nxt = rarst_pkg::ST_IDLE;
      end
      default: state_nxt = rarst_pkg::ST_CLEAR;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    id_nxt        = id_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    d_nxt         = d_r;
    is_sum_nxt    = is_sum_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = id_r;
    mem_wtag      = rd_tag;
    mem_wtotal    = rd_total;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    push          = 1'b0;
    push_data     = {rid, mid, r_r};
    pop           = 1'b0;
    case (state_r)
      rarst_pkg::ST_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_r;
        mem_wtag   = '0;
        mem_wtotal = '0;
        clr_nxt    = clr_r + IDW'(1);
      end
      rarst_pkg::ST_IDLE: begin
        if (in_fire) begin
          a_nxt      = lo_x;
          b_nxt      = hi_c;
          d_nxt      = in_delta;
          is_sum_nxt = (in_cmd == rarst_pkg::CMD_SUM);
          acc_nxt    = '0;
          id_nxt     = '0;
          l_nxt      = '0;
          r_nxt      = pos_x;
          clr_nxt    = '0;
          mem_re     = 1'b1;
          mem_raddr  = '0;
        end
      end
      rarst_pkg::ST_MUL: begin
        prod_nxt = (is_sum_r && full) ? rd_total : mul_ext;
      end
      rarst_pkg::ST_MUL2: begin
        prod_nxt = prod_r + {mul_ext[31:0], 32'b0};
      end
      rarst_pkg::ST_WB: begin
        if (is_sum_r) begin
          acc_nxt = acc_r + prod_r;
        end else begin
          // Overlap times delta goes into the total; a covered node also adds delta to its tag.
          mem_we     = 1'b1;
          mem_wtag   = full ? rd_tag + {{32{d_r[31]}}, d_r} : rd_tag;
          mem_wtotal = rd_total + prod_r;
        end
        if (!full && lint) begin
          push   = rint;
          id_nxt = lid;
          r_nxt  = mid;
        end else if (!full && rint) begin
          id_nxt = rid;
          l_nxt  = mid;
        end else if (!stk_empty) begin
          pop = 1'b1;
          {id_nxt, l_nxt, r_nxt} = stk_top;
        end
        mem_re    = have_next;
        mem_raddr = id_nxt;
      end
      rarst_pkg::ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = acc_r;
        end
      end
      default: begin
        clr_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rarst_pkg::ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r       <= id_nxt;
    l_r        <= l_nxt;
    r_r        <= r_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    d_r        <= d_nxt;
    is_sum_r   <= is_sum_nxt;
    acc_r      <= acc_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rarst_pkg::ST_CLEAR) |-> !in_tready)
    else $error("input accepted during memory clear");

  a_high_half_follows_low: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rarst_pkg::ST_MUL2) |-> ($past(state_r) == rarst_pkg::ST_MUL))
    else $error("high half product without low half");

  a_write_only_in_wb_or_clear: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == rarst_pkg::ST_CLEAR || state_r == rarst_pkg::ST_WB))
    else $error("node memory written outside write back or clear");

  a_no_push_and_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && pop))
    else $error("stack pushed and popped in the same cycle");

endmodule

>>> rtl/core/rarst_node_mem.sv
module rarst_node_mem #(
  parameter int DEPTH = 2047,
  parameter int AW    = 11
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [rarst_pkg::SUM_W-1:0] wr_tag,
  input  logic [rarst_pkg::SUM_W-1:0] wr_total,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [rarst_pkg::SUM_W-1:0] rd_tag_r,
  output logic [rarst_pkg::SUM_W-1:0] rd_total_r
);

  logic [rarst_pkg::SUM_W-1:0] tag_mem   [DEPTH];
  logic [rarst_pkg::SUM_W-1:0] total_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_mem[wr_addr]   <= wr_tag;
      total_mem[wr_addr] <= wr_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_tag_r   <= tag_mem[rd_addr];
      rd_total_r <= total_mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/rarst_node_stack.sv
module rarst_node_stack #(
  parameter int W     = 33,
  parameter int DEPTH = 11
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] top,
  output logic         empty
);

  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PTR_W = $clog2(DEPTH + 1);

  logic [W-1:0]     slot_r [DEPTH];
  logic [PTR_W-1:0] cnt_r;
  logic [PTR_W-1:0] top_idx;

  assign top_idx = cnt_r - PTR_W'(1);
  assign top     = slot_r[top_idx[IW-1:0]];
  assign empty   = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[cnt_r[IW-1:0]] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (push) begin
      cnt_r <= cnt_r + PTR_W'(1);
    end else if (pop) begin
      cnt_r <= cnt_r - PTR_W'(1);
    end
  end

endmodule
